>>> design/plsf_pkg.sv
`default_nettype none

package plsf_pkg;

    // event codes carried in the input tuser
    typedef enum logic [3:0] {
        OP_SUPERVISE = 4'd0,
        OP_LOCKOUT   = 4'd1,
        OP_RELEASE   = 4'd2,
        OP_OFFHOOK   = 4'd3,
        OP_ONHOOK    = 4'd4,
        OP_DIGITS    = 4'd5,
        OP_FLASH     = 4'd6,
        OP_ALERTING  = 4'd7,
        OP_BAD_IN    = 4'd8,
        OP_BAD_OUT   = 4'd9
    } op_t;

    // line state machine, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_ACTIVE = 5'b00010,
        MODE_ORIG   = 5'b00100,
        MODE_TERM   = 5'b01000,
        MODE_LOCK   = 5'b10000
    } mode_t;

    // line state codes as reported
    localparam logic [2:0] LINE_IDLE   = 3'd0;
    localparam logic [2:0] LINE_ACTIVE = 3'd1;
    localparam logic [2:0] LINE_ORIG   = 3'd2;
    localparam logic [2:0] LINE_TERM   = 3'd3;
    localparam logic [2:0] LINE_LOCK   = 3'd4;

    // upstream signal codes
    localparam logic [2:0] SIG_NONE     = 3'd0;
    localparam logic [2:0] SIG_OFFHOOK  = 3'd1;
    localparam logic [2:0] SIG_ALERTING = 3'd2;
    localparam logic [2:0] SIG_DIGITS   = 3'd3;
    localparam logic [2:0] SIG_FLASH    = 3'd4;
    localparam logic [2:0] SIG_ONHOOK   = 3'd5;

    // configuration register indexes
    localparam logic CFG_ALERT_TIMEOUT = 1'b0;
    localparam logic CFG_RESET_CAUSE   = 1'b1;

    localparam int unsigned CAUSE_W = 8;

    typedef struct packed {
        op_t                op;
        logic               has_ring;
        logic               ring_on;
        logic               has_scan;
        logic               scan_digits;
        logic               scan_flash;
        logic               has_cause;
        logic [CAUSE_W-1:0] cause_value;
        logic               rx_is_silent;
    } item_t;

    typedef struct packed {
        logic               alerting_timeout_wanted;
        logic [CAUSE_W-1:0] reset_cause_code;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         line_state;
        logic               offhook_now;
        logic               ringing_now;
        logic               report_digits;
        logic               report_flash;
        logic [CAUSE_W-1:0] cause_now;
        logic [2:0]         sent_signal;
        logic               connect_silent;
        logic               invalid_incoming;
        logic               invalid_outgoing;
        logic               circuit_was_reset;
    } result_t;

    function automatic logic [2:0] mode_code(mode_t m);
        logic [2:0] c;
        unique case (m)
            MODE_IDLE:   c = LINE_IDLE;
            MODE_ACTIVE: c = LINE_ACTIVE;
            MODE_ORIG:   c = LINE_ORIG;
            MODE_TERM:   c = LINE_TERM;
            MODE_LOCK:   c = LINE_LOCK;
            default:     c = LINE_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/plsf_in_stage.sv
`default_nettype none

module plsf_in_stage (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  plsf_pkg::item_t   s_item,
    input  wire               advance,
    output logic              item_valid,
    output plsf_pkg::item_t   item
);

    logic            valid_reg, valid_next;
    plsf_pkg::item_t item_reg;

    // takes a beat when empty or when the held one moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> design/plsf_engine.sv
`default_nettype none

module plsf_engine (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                fire,
    input  plsf_pkg::item_t    item,
    input  plsf_pkg::cfg_t     cfg,
    output plsf_pkg::result_t  result
);

    plsf_pkg::mode_t                 mode_reg, mode_next;
    logic                            offhook_reg, offhook_next;
    logic                            ringing_reg, ringing_next;
    logic                            digits_reg, digits_next;
    logic                            flash_reg, flash_next;
    logic [plsf_pkg::CAUSE_W-1:0]    cause_reg, cause_next;

    always_comb begin
        logic [2:0] sent;
        logic       silent;
        logic       bad_in;
        logic       bad_out;
        logic       was_reset;
        logic       dirty;

        mode_next    = mode_reg;
        offhook_next = offhook_reg;
        ringing_next = ringing_reg;
        digits_next  = digits_reg;
        flash_next   = flash_reg;
        cause_next   = cause_reg;
        sent         = plsf_pkg::SIG_NONE;
        silent       = 1'b0;
        bad_in       = 1'b0;
        bad_out      = 1'b0;
        was_reset    = 1'b0;

        // anything away from its reset value, or the path not yet silent
        dirty = !item.rx_is_silent || (mode_reg != plsf_pkg::MODE_IDLE) || offhook_reg ||
                ringing_reg || digits_reg || flash_reg || (cause_reg != '0);

        unique case (item.op)
            plsf_pkg::OP_SUPERVISE: begin
                if (mode_next == plsf_pkg::MODE_IDLE) begin
                    mode_next = plsf_pkg::MODE_TERM;
                end
                if (item.has_ring) begin
                    if (item.ring_on) begin
                        ringing_next = 1'b1;
                        if (mode_next == plsf_pkg::MODE_ACTIVE) begin
                            mode_next = plsf_pkg::MODE_TERM;
                        end
                        if (!offhook_reg) begin
                            if (!cfg.alerting_timeout_wanted) begin
                                sent = plsf_pkg::SIG_ALERTING;
                            end
                        end else begin
                            sent = plsf_pkg::SIG_OFFHOOK;
                        end
                    end else begin
                        ringing_next = 1'b0;
                    end
                end
                if (item.has_scan) begin
                    digits_next = item.scan_digits;
                    flash_next  = item.scan_flash;
                    if (mode_next == plsf_pkg::MODE_ACTIVE && item.scan_digits) begin
                        mode_next = plsf_pkg::MODE_ORIG;
                    end
                end
                if (item.has_cause) begin
                    cause_next = item.cause_value;
                end
            end
            plsf_pkg::OP_LOCKOUT: begin
                mode_next   = plsf_pkg::MODE_LOCK;
                digits_next = 1'b0;
                flash_next  = 1'b0;
                silent      = 1'b1;
            end
            plsf_pkg::OP_RELEASE: begin
                if (item.has_cause && item.cause_value == cfg.reset_cause_code) begin
                    // full circuit reset, only when something is set
                    if (dirty) begin
                        silent       = 1'b1;
                        mode_next    = plsf_pkg::MODE_IDLE;
                        offhook_next = 1'b0;
                        ringing_next = 1'b0;
                        digits_next  = 1'b0;
                        flash_next   = 1'b0;
                        cause_next   = '0;
                        was_reset    = 1'b1;
                    end
                end else begin
                    mode_next    = offhook_reg ? plsf_pkg::MODE_ACTIVE : plsf_pkg::MODE_IDLE;
                    silent       = 1'b1;
                    ringing_next = 1'b0;
                    digits_next  = 1'b0;
                    flash_next   = 1'b0;
                    cause_next   = '0;
                    if (offhook_reg) begin
                        sent = plsf_pkg::SIG_OFFHOOK;
                    end
                end
            end
            plsf_pkg::OP_OFFHOOK: begin
                offhook_next = 1'b1;
                if (mode_reg == plsf_pkg::MODE_IDLE) begin
                    mode_next = plsf_pkg::MODE_ACTIVE;
                end
                sent = plsf_pkg::SIG_OFFHOOK;
            end
            plsf_pkg::OP_ONHOOK: begin
                if (offhook_reg) begin
                    offhook_next = 1'b0;
                    digits_next  = 1'b0;
                    if (mode_reg == plsf_pkg::MODE_ACTIVE) begin
                        mode_next = plsf_pkg::MODE_IDLE;
                    end
                    sent = plsf_pkg::SIG_ONHOOK;
                end else begin
                    bad_out = 1'b1;
                end
            end
            plsf_pkg::OP_DIGITS: begin
                if (digits_reg) sent = plsf_pkg::SIG_DIGITS;
                else            bad_out = 1'b1;
            end
            plsf_pkg::OP_FLASH: begin
                if (flash_reg) sent = plsf_pkg::SIG_FLASH;
                else           bad_out = 1'b1;
            end
            plsf_pkg::OP_ALERTING: begin
                if (ringing_reg) sent = plsf_pkg::SIG_ALERTING;
                else             bad_out = 1'b1;
            end
            plsf_pkg::OP_BAD_OUT: begin
                bad_out = 1'b1;
            end
            default: begin
                // bad incoming and unused codes
                bad_in = 1'b1;
            end
        endcase

        result.line_state        = plsf_pkg::mode_code(mode_next);
        result.offhook_now       = offhook_next;
        result.ringing_now       = ringing_next;
        result.report_digits     = digits_next;
        result.report_flash      = flash_next;
        result.cause_now         = cause_next;
        result.sent_signal       = sent;
        result.connect_silent    = silent;
        result.invalid_incoming  = bad_in;
        result.invalid_outgoing  = bad_out;
        result.circuit_was_reset = was_reset;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= plsf_pkg::MODE_IDLE;
            offhook_reg <= 1'b0;
            ringing_reg <= 1'b0;
            digits_reg  <= 1'b0;
            flash_reg   <= 1'b0;
            cause_reg   <= '0;
        end else if (fire) begin
            mode_reg    <= mode_next;
            offhook_reg <= offhook_next;
            ringing_reg <= ringing_next;
            digits_reg  <= digits_next;
            flash_reg   <= flash_next;
            cause_reg   <= cause_next;
        end
    end

endmodule

`default_nettype wire

>>> design/phone_line_supervision_fsm.sv
`default_nettype none

// subscriber-line supervision machine: one event per input beat (op in s_tuser, its
// parameters in s_tdata) gives one result beat with the line state and flags after
// the event, the upstream signal, the silence switch and the invalid and reset marks.
// a new event is taken every cycle unless m_tready stalls; each event passes through
// the input register and then the result register. the line state lives in the engine
// and is updated in the same cycle that the result register loads, so back-to-back
// events always see the state left by the one before. a stalled m_tready holds the
// result and, once the input register is full, the input side. configuration goes
// through cfg_wr_en/cfg_addr/cfg_wdata into registers; write it only while no event
// is in flight

module phone_line_supervision_fsm (
    input  wire         aclk,
    input  wire         aresetn,
    // event beat
    input  wire         s_tvalid,
    output logic        s_tready,
    // [0] has_ring, [1] ring_on, [2] has_scan, [3] scan_digits, [4] scan_flash,
    // [5] has_cause, [13:6] cause_value, [14] rx_is_silent, [15] zero
    input  wire  [15:0] s_tdata,
    // [3:0] op
    input  wire  [3:0]  s_tuser,
    // result beat
    output logic        m_tvalid,
    input  wire         m_tready,
    // [2:0] line_state, [3] offhook_now, [4] ringing_now, [5] report_digits,
    // [6] report_flash, [14:7] cause_now, [17:15] sent_signal, [18] connect_silent,
    // [19] invalid_incoming, [20] invalid_outgoing, [21] circuit_was_reset, [23:22] zero
    output logic [23:0] m_tdata,
    // configuration writes
    input  wire         cfg_wr_en,
    input  wire         cfg_addr,
    input  wire  [7:0]  cfg_wdata
);

    plsf_pkg::item_t   s_item;
    plsf_pkg::item_t   item;
    plsf_pkg::result_t result;
    plsf_pkg::cfg_t    cfg_reg;

    logic        item_valid;
    logic        fire;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg, m_tdata_next;

    // unpack the event beat
    assign s_item.op           = plsf_pkg::op_t'(s_tuser);
    assign s_item.has_ring     = s_tdata[0];
    assign s_item.ring_on      = s_tdata[1];
    assign s_item.has_scan     = s_tdata[2];
    assign s_item.scan_digits  = s_tdata[3];
    assign s_item.scan_flash   = s_tdata[4];
    assign s_item.has_cause    = s_tdata[5];
    assign s_item.cause_value  = s_tdata[13:6];
    assign s_item.rx_is_silent = s_tdata[14];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alerting_timeout_wanted <= 1'b0;
            cfg_reg.reset_cause_code        <= 8'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                plsf_pkg::CFG_ALERT_TIMEOUT: cfg_reg.alerting_timeout_wanted <= cfg_wdata[0];
                plsf_pkg::CFG_RESET_CAUSE:   cfg_reg.reset_cause_code        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // the held event is processed whenever the result register is free or draining
    assign fire = item_valid && (!m_tvalid_reg || m_tready);

    plsf_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    plsf_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // pack the result beat, highest field first
    assign m_tdata_next = {2'b00,
                           result.circuit_was_reset,
                           result.invalid_outgoing,
                           result.invalid_incoming,
                           result.connect_silent,
                           result.sent_signal,
                           result.cause_now,
                           result.report_flash,
                           result.report_digits,
                           result.ringing_now,
                           result.offhook_now,
                           result.line_state};

    assign m_tvalid_next = fire || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // a processed event always lands in the result register
    a_fire_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid)
        else $error("processed event did not reach the result register");

    // a lockout always reports the locked-out state with reporting off
    a_lockout: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.op == plsf_pkg::OP_LOCKOUT |=>
            m_tdata[2:0] == plsf_pkg::LINE_LOCK && !m_tdata[5] && !m_tdata[6] && m_tdata[18])
        else $error("lockout result wrong");

    // a circuit reset leaves every state field at its reset value
    a_reset_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] |->
            m_tdata[2:0] == plsf_pkg::LINE_IDLE && m_tdata[6:3] == 4'b0000 &&
            m_tdata[14:7] == 8'd0 && m_tdata[18])
        else $error("circuit reset left state behind");

    // a held event is not lost while the result side stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && !fire |=> item_valid)
        else $error("held event dropped");
`endif

endmodule

`default_nettype wire
